FILE: rtl/mrfp_pkg.sv
package mrfp_pkg;

  localparam int unsigned FRAME_BUFFER_BYTES_DEF = 8;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned POS_W  = 32;

  localparam logic [BYTE_W-1:0] CODE_POSITION   = 8'h36;
  localparam logic [BYTE_W-1:0] CODE_FLAGS      = 8'h3A;
  localparam logic [BYTE_W-1:0] CODE_ZERO_ACK   = 8'h0A;
  localparam logic [BYTE_W-1:0] CODE_ENABLE_ACK = 8'hF3;
  localparam logic [BYTE_W-1:0] CODE_MOVE_ACK   = 8'hFD;
  localparam logic [BYTE_W-1:0] FRAME_END       = 8'h6B;

  localparam logic [LEN_W-1:0] LEN_NONE     = 4'd0;
  localparam logic [LEN_W-1:0] LEN_POSITION = 4'd8;
  localparam logic [LEN_W-1:0] LEN_SHORT    = 4'd4;

  localparam logic [KIND_W-1:0] KIND_POSITION = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FLAGS    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPLY    = 2'd2;

  localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h01;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] byte2;
    logic [POS_W-1:0]  magnitude;
  } frame_rec_t;

  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } q_push_t;

  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } q_head_t;

  function automatic logic [LEN_W-1:0] length_for_code(input logic [BYTE_W-1:0] code);
    logic [LEN_W-1:0] len;
    case (code)
      CODE_POSITION:   len = LEN_POSITION;
      CODE_FLAGS:      len = LEN_SHORT;
      CODE_ZERO_ACK:   len = LEN_SHORT;
      CODE_ENABLE_ACK: len = LEN_SHORT;
      CODE_MOVE_ACK:   len = LEN_SHORT;
      default:         len = LEN_NONE;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/motor_reply_frame_parser_core.sv
// Reply frame parser for a stepper driver serial link.
// Input channel: one received byte per transfer (in_valid, in_stall, in_rx_byte).
// A frame starts with the configured address byte, then a command code that sets
// its length (8 bytes for a position report, 4 for flags or a command reply), and
// must end in the terminator 0x6B; anything else is dropped without a result.
// Result channel: one transfer per good frame (out_valid, out_stall, kind and the
// fields of that kind; fields of other kinds read as zero).
// Configuration: cfg_valid/cfg_ready write the device address (reset 1);
// cfg_ready is always high. Write only while no frame is in progress.
// Throughput: one byte per cycle while in_stall is low.
// A good frame enters the queue when its terminator byte transfers; out_valid
// rises once the output register loads it from the queue head, but a position
// report whose magnitude has bit 31 set is popped without a result.
// Reset clears the parser, the two-entry frame queue and the output valid flag.
// When the receiver stalls, the result holds in the output register and further
// frames fill the queue; once it is full, in_stall rises until a slot frees.
module motor_reply_frame_parser_core
  import mrfp_pkg::*;
#(
  parameter int unsigned FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [BYTE_W-1:0]       cfg_device_address,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [BYTE_W-1:0]       in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [KIND_W-1:0]       out_frame_kind,
  output logic signed [POS_W-1:0] out_position,
  output logic [BYTE_W-1:0]       out_flag_bits,
  output logic [BYTE_W-1:0]       out_reply_code,
  output logic [BYTE_W-1:0]       out_reply_status
);

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  mrfp_front #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_device_address (cfg_device_address),
    .in_valid           (in_valid),
    .in_rx_byte         (in_rx_byte),
    .q_full             (q_full),
    .q_push             (q_push)
  );

  mrfp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  mrfp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_kind   (out_frame_kind),
    .out_position     (out_position),
    .out_flag_bits    (out_flag_bits),
    .out_reply_code   (out_reply_code),
    .out_reply_status (out_reply_status)
  );

endmodule

FILE: rtl/mrfp_front.sv
module mrfp_front
  import mrfp_pkg::*;
#(
  parameter int unsigned FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [BYTE_W-1:0] cfg_device_address,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              q_full,
  output q_push_t           q_push
);

  localparam int unsigned IDX_W = $clog2(FRAME_BUFFER_BYTES);
  localparam int unsigned CNT_W = $clog2(FRAME_BUFFER_BYTES + 1);
  localparam logic [CNT_W-1:0] BUF_FULL = CNT_W'(FRAME_BUFFER_BYTES);

  localparam logic [1:0] PH_ADDR    = 2'd0;
  localparam logic [1:0] PH_CMD     = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  logic [BYTE_W-1:0] device_address_r;
  logic [1:0]        phase_r, phase_nxt;
  logic [CNT_W-1:0]  byte_index_r, byte_index_nxt;
  logic [LEN_W-1:0]  frame_length_r, frame_length_nxt;
  logic [BYTE_W-1:0] frame_bytes_r [FRAME_BUFFER_BYTES];
  logic              accept;
  logic              buf_we;
  logic              push;
  logic [CNT_W-1:0]  index_inc;

  assign accept    = in_valid && !q_full;
  assign index_inc = byte_index_r + CNT_W'(1);

  always_comb begin
    phase_nxt        = phase_r;
    byte_index_nxt   = byte_index_r;
    frame_length_nxt = frame_length_r;
    buf_we           = 1'b0;
    push             = 1'b0;
    if (accept) begin
      case (phase_r)
        PH_ADDR: begin
          if (in_rx_byte == device_address_r) begin
            byte_index_nxt = CNT_W'(1);
            phase_nxt      = PH_CMD;
          end
        end
        PH_CMD: begin
          if (byte_index_r >= BUF_FULL) begin
            phase_nxt      = PH_ADDR;
            byte_index_nxt = '0;
          end else begin
            buf_we           = 1'b1;
            byte_index_nxt   = index_inc;
            frame_length_nxt = length_for_code(in_rx_byte);
            if (frame_length_nxt == LEN_NONE) begin
              phase_nxt      = PH_ADDR;
              byte_index_nxt = '0;
            end else begin
              phase_nxt = PH_COLLECT;
            end
          end
        end
        PH_COLLECT: begin
          if (byte_index_r >= BUF_FULL) begin
            phase_nxt      = PH_ADDR;
            byte_index_nxt = '0;
          end else begin
            buf_we         = 1'b1;
            byte_index_nxt = index_inc;
            if (index_inc >= CNT_W'(frame_length_r)) begin
              push           = (in_rx_byte == FRAME_END);
              phase_nxt      = PH_ADDR;
              byte_index_nxt = '0;
            end
          end
        end
        default: begin
          phase_nxt      = PH_ADDR;
          byte_index_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= ADDR_RESET;
      phase_r          <= PH_ADDR;
      byte_index_r     <= '0;
      frame_length_r   <= LEN_NONE;
    end else begin
      if (cfg_valid) begin
        device_address_r <= cfg_device_address;
      end
      phase_r        <= phase_nxt;
      byte_index_r   <= byte_index_nxt;
      frame_length_r <= frame_length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      frame_bytes_r[byte_index_r[IDX_W-1:0]] <= in_rx_byte;
    end
  end

  assign q_push.valid         = push;
  assign q_push.rec.code      = frame_bytes_r[1];
  assign q_push.rec.byte2     = frame_bytes_r[2];
  assign q_push.rec.magnitude = {frame_bytes_r[3], frame_bytes_r[4],
                                 frame_bytes_r[5], frame_bytes_r[6]};

`ifndef SYNTHESIS
  a_collect_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COLLECT) |-> (frame_length_r != LEN_NONE))
    else $error("collecting without a frame length");

  a_index_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ADDR) |-> (byte_index_r == '0))
    else $error("byte index not cleared while waiting for address");
`endif

endmodule

FILE: rtl/mrfp_queue.sv
module mrfp_queue
  import mrfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t q_push,
  output logic    q_full,
  output q_head_t q_head,
  input  logic    q_pop
);

  frame_rec_t         entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign q_full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_head.valid = (count_r != '0);
  assign q_head.rec   = entries_r[rd_ptr_r];

  assign do_push = q_push.valid && !q_full;
  assign do_pop  = q_pop && q_head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + Q_CNT_W'(1);
      2'b01:   count_nxt = count_r - Q_CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= q_push.rec;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push.valid)
    else $error("transfer pushed into a full queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

FILE: rtl/mrfp_back.sv
module mrfp_back
  import mrfp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  q_head_t                 q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [KIND_W-1:0]       out_frame_kind,
  output logic signed [POS_W-1:0] out_position,
  output logic [BYTE_W-1:0]       out_flag_bits,
  output logic [BYTE_W-1:0]       out_reply_code,
  output logic [BYTE_W-1:0]       out_reply_status
);

  logic                    out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]       kind_r, kind_nxt;
  logic signed [POS_W-1:0] position_r, position_nxt;
  logic [BYTE_W-1:0]       flag_bits_r, flag_bits_nxt;
  logic [BYTE_W-1:0]       reply_code_r, reply_code_nxt;
  logic [BYTE_W-1:0]       reply_status_r, reply_status_nxt;
  logic                    slot_free;
  logic                    drop;

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = q_head.valid && slot_free;

  always_comb begin
    kind_nxt         = KIND_REPLY;
    position_nxt     = '0;
    flag_bits_nxt    = '0;
    reply_code_nxt   = '0;
    reply_status_nxt = '0;
    drop             = 1'b0;
    case (q_head.rec.code)
      CODE_POSITION: begin
        kind_nxt = KIND_POSITION;
        drop     = q_head.rec.magnitude[POS_W-1];
        position_nxt = (q_head.rec.byte2 != '0) ? -$signed(q_head.rec.magnitude)
                                                : $signed(q_head.rec.magnitude);
      end
      CODE_FLAGS: begin
        kind_nxt      = KIND_FLAGS;
        flag_bits_nxt = q_head.rec.byte2;
      end
      default: begin
        kind_nxt         = KIND_REPLY;
        reply_code_nxt   = q_head.rec.code;
        reply_status_nxt = q_head.rec.byte2;
      end
    endcase
    out_valid_nxt = slot_free ? (q_head.valid && !drop) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r         <= kind_nxt;
      position_r     <= position_nxt;
      flag_bits_r    <= flag_bits_nxt;
      reply_code_r   <= reply_code_nxt;
      reply_status_r <= reply_status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_kind   = kind_r;
  assign out_position     = position_r;
  assign out_flag_bits    = flag_bits_r;
  assign out_reply_code   = reply_code_r;
  assign out_reply_status = reply_status_r;

`ifndef SYNTHESIS
  a_position_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == KIND_POSITION)) |-> (position_r != 32'sh8000_0000))
    else $error("position transfer with oversized magnitude");
`endif

endmodule

FILE: test/tb_motor_reply_frame_parser_core.sv
`timescale 1ns / 100ps

module tb_motor_reply_frame_parser_core;
  import mrfp_pkg::*;

  typedef enum logic [1:0] {PH_ADDR, PH_CODE, PH_COLLECT} parse_phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]       frame_kind;
    logic signed [POS_W-1:0] position;
    logic [BYTE_W-1:0]       flag_bits;
    logic [BYTE_W-1:0]       reply_code;
    logic [BYTE_W-1:0]       reply_status;
  } frame_reply_t;

  localparam int unsigned BUF_BYTES = FRAME_BUFFER_BYTES_DEF;
  localparam int unsigned N_OPENING = 35;
  localparam int unsigned SEGMENT_BYTES = 265;
  localparam int unsigned SETTLE_CYCLES = 8;

  localparam logic [BYTE_W-1:0] OPENING [N_OPENING] = '{
    8'hFF,
    ADDR_RESET, CODE_POSITION, 8'h80, 8'h7F, 8'hFF, 8'hFF, 8'hFF, FRAME_END,
    ADDR_RESET, CODE_POSITION, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, FRAME_END,
    ADDR_RESET, CODE_FLAGS, 8'hFF, FRAME_END,
    ADDR_RESET, CODE_MOVE_ACK, 8'h00, FRAME_END,
    ADDR_RESET, CODE_ZERO_ACK, 8'hA5, FRAME_END,
    ADDR_RESET, 8'h77,
    ADDR_RESET, CODE_ENABLE_ACK, 8'h5A, 8'h6A
  };

  class reply_scoreboard;
    logic [BYTE_W-1:0] address;
    parse_phase_t      phase;
    logic [BYTE_W-1:0] frame_buf [BUF_BYTES];
    int unsigned       fill;
    logic [LEN_W-1:0]  length;
    frame_reply_t      expected_q [$];
    int unsigned       failures;

    function new();
      address = ADDR_RESET;
      phase = PH_ADDR;
      fill = 0;
      length = LEN_NONE;
      failures = 0;
    endfunction

    function logic [LEN_W-1:0] frame_length_of(logic [BYTE_W-1:0] code);
      if (code == CODE_POSITION) return LEN_POSITION;
      if (code == CODE_FLAGS || code == CODE_ZERO_ACK || code == CODE_ENABLE_ACK ||
          code == CODE_MOVE_ACK) return LEN_SHORT;
      return LEN_NONE;
    endfunction

    function void decode_frame();
      frame_reply_t r;
      logic [POS_W-1:0] mag;
      logic [BYTE_W-1:0] code;
      code = frame_buf[1];
      r = '0;
      if (code == CODE_POSITION) begin
        mag = {frame_buf[3], frame_buf[4], frame_buf[5], frame_buf[6]};
        if (mag[POS_W-1]) return;
        r.frame_kind = KIND_POSITION;
        r.position = (frame_buf[2] != 8'h00) ? -mag : mag;
      end else if (code == CODE_FLAGS) begin
        r.frame_kind = KIND_FLAGS;
        r.flag_bits = frame_buf[2];
      end else begin
        r.frame_kind = KIND_REPLY;
        r.reply_code = code;
        r.reply_status = frame_buf[2];
      end
      expected_q.push_back(r);
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      case (phase)
        PH_ADDR: begin
          if (b == address) begin
            frame_buf[0] = b;
            fill = 1;
            phase = PH_CODE;
          end
        end
        PH_CODE: begin
          frame_buf[fill] = b;
          fill++;
          length = frame_length_of(b);
          phase = (length == LEN_NONE) ? PH_ADDR : PH_COLLECT;
        end
        PH_COLLECT: begin
          if (fill >= BUF_BYTES) begin
            phase = PH_ADDR;
          end else begin
            frame_buf[fill] = b;
            fill++;
            if (fill >= length) begin
              if (b == FRAME_END) decode_frame();
              phase = PH_ADDR;
            end
          end
        end
        default: phase = PH_ADDR;
      endcase
      if (phase == PH_ADDR && b != address) fill = 0;
    endfunction

    function void check_result(frame_reply_t got);
      frame_reply_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with none expected: kind %0d", got.frame_kind);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (got.frame_kind !== want.frame_kind) begin
        $error("frame_kind: expected %0d, got %0d", want.frame_kind, got.frame_kind);
        failures++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        failures++;
      end
      if (got.flag_bits !== want.flag_bits) begin
        $error("flag_bits: expected %0h, got %0h", want.flag_bits, got.flag_bits);
        failures++;
      end
      if (got.reply_code !== want.reply_code) begin
        $error("reply_code: expected %0h, got %0h", want.reply_code, got.reply_code);
        failures++;
      end
      if (got.reply_status !== want.reply_status) begin
        $error("reply_status: expected %0h, got %0h", want.reply_status, got.reply_status);
        failures++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [BYTE_W-1:0]       cfg_device_address;
  logic                    in_valid;
  logic                    in_stall;
  logic [BYTE_W-1:0]       in_rx_byte;
  logic                    out_valid;
  logic                    out_stall;
  logic [KIND_W-1:0]       out_frame_kind;
  logic signed [POS_W-1:0] out_position;
  logic [BYTE_W-1:0]       out_flag_bits;
  logic [BYTE_W-1:0]       out_reply_code;
  logic [BYTE_W-1:0]       out_reply_status;

  reply_scoreboard board = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned bytes_sent;

  motor_reply_frame_parser_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_device_address (cfg_device_address),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_kind     (out_frame_kind),
    .out_position       (out_position),
    .out_flag_bits      (out_flag_bits),
    .out_reply_code     (out_reply_code),
    .out_reply_status   (out_reply_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("motor_reply_frame_parser_core verification failed");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result('{out_frame_kind, out_position, out_flag_bits,
                           out_reply_code, out_reply_status});
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    board.note_byte(b);
    bytes_sent++;
  endtask

  // pad out any frame in progress, then hold off input until every expected result has been transferred
  task automatic drain_results();
    while (board.phase != PH_ADDR) send_byte(8'h00);
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [BYTE_W-1:0] a);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_device_address <= a;
    do @(posedge clk); while (!cfg_ready);
    board.address = a;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame();
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] term;
    logic [BYTE_W-1:0] sign;
    logic [POS_W-1:0]  mag;
    int unsigned       pick;
    int unsigned       body;
    pick = $urandom_range(99);
    case ($urandom_range(5))
      0, 1: code = CODE_POSITION;
      2: code = CODE_FLAGS;
      3: code = CODE_ZERO_ACK;
      4: code = CODE_ENABLE_ACK;
      default: code = CODE_MOVE_ACK;
    endcase
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      return;
    end
    send_byte(board.address);
    if (pick < 13) begin
      code = 8'($urandom);
      if (board.frame_length_of(code) != LEN_NONE) code = 8'h00;
      send_byte(code);
      return;
    end
    send_byte(code);
    body = (code == CODE_POSITION) ? 6 : 2;
    if (pick < 18) begin
      repeat ($urandom_range(0, body - 1)) send_byte(8'($urandom));
      return;
    end
    term = FRAME_END;
    if (pick < 28) begin
      term = 8'($urandom);
      if (term == FRAME_END) term = ~FRAME_END;
    end
    if (code == CODE_POSITION) begin
      sign = $urandom_range(1) ? 8'h00 : 8'($urandom);
      case ($urandom_range(7))
        0: mag = 32'h0000_0000;
        1: mag = 32'h7FFF_FFFF;
        2: mag = 32'h8000_0000;
        3: mag = 32'hFFFF_FFFF;
        4: mag = $urandom;
        default: mag = $urandom >> 1;
      endcase
      send_byte(sign);
      send_byte(mag[31:24]);
      send_byte(mag[23:16]);
      send_byte(mag[15:8]);
      send_byte(mag[7:0]);
    end else begin
      send_byte(8'($urandom));
    end
    send_byte(term);
  endtask

  initial begin
    logic [BYTE_W-1:0] seg_address [6];
    int unsigned target;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_device_address = '0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    bytes_sent = 0;
    seg_address = '{8'hFF, 8'h00, FRAME_END, CODE_POSITION, 8'($urandom), 8'($urandom)};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_OPENING; i++) send_byte(OPENING[i]);

    for (int seg = 0; seg < 6; seg++) begin
      write_address(seg_address[seg]);
      case (seg / 2)
        0: begin
          send_idle_pct = 10;
          recv_stall_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_stall_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      target = bytes_sent + SEGMENT_BYTES;
      while (bytes_sent < target) send_frame();
    end

    drain_results();
    if (board.failures == 0)
      $display("motor_reply_frame_parser_core verification clean");
    else
      $display("motor_reply_frame_parser_core verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mrfp_pkg.sv
rtl/mrfp_front.sv
rtl/mrfp_queue.sv
rtl/mrfp_back.sv
rtl/motor_reply_frame_parser_core.sv
test/tb_motor_reply_frame_parser_core.sv
